[hdl/foc_voltage_sine_pwm_unit_assert.svh]
// ----------------------------------------------------------------------------
// FOC sine PWM unit assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FOC_VOLTAGE_SINE_PWM_UNIT_ASSERT_SVH
`define FOC_VOLTAGE_SINE_PWM_UNIT_ASSERT_SVH

// Same-cycle implication
`define FVSP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FVSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/fvsp_pkg.sv]
// ----------------------------------------------------------------------------
// FOC sine PWM package
// Constants, register codes, the divider step and the voltage clamp of the sine PWM unit.
// ----------------------------------------------------------------------------
package fvsp_pkg;

  // Pipeline layout
  localparam int unsigned PIPE_DEPTH  = 13;
  localparam int unsigned DIV_STAGES  = 4;
  localparam int unsigned NUM_PHASES  = 3;

  // Register reset values
  localparam logic [15:0] SUPPLY_RST  = 16'd5000;
  localparam logic [15:0] OFFSET_RST  = 16'd0;

  // Quarter-wave sine polynomial, Q15
  localparam logic [16:0] SIN_A       = 17'd51472;
  localparam logic [14:0] SIN_B       = 15'd21024;
  localparam logic [11:0] SIN_C       = 12'd2320;
  localparam logic [14:0] SIN_SAT     = 15'd32767;
  localparam logic [14:0] QUARTER_X   = 15'd16384;
  localparam logic [15:0] QUARTER_PH  = 16'h4000;

  // sqrt(3) in Q16
  localparam logic [17:0] SQRT3_Q16   = 18'd113512;

  typedef enum logic [1:0] {
    CFG_SUPPLY_MV   = 2'd0,
    CFG_ZERO_OFFSET = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [23:0] rem;
    logic [7:0]  q;
  } div_t;

  // One restoring division step at quotient bit sh
  function automatic div_t div_step(div_t a, logic [15:0] d, logic [2:0] sh);
    div_t        o;
    logic [23:0] den;
    o   = a;
    den = 24'(d) << sh;
    if ((d != '0) && (a.rem >= den)) begin
      o.rem   = a.rem - den;
      o.q[sh] = 1'b1;
    end
    return o;
  endfunction

  // Clamp a phase voltage to 0..vmax
  function automatic logic [32:0] clamp_v(logic signed [35:0] v, logic [32:0] vmax);
    logic [32:0] o;
    if (v < 0) begin
      o = '0;
    end else if (v > $signed({3'b000, vmax})) begin
      o = vmax;
    end else begin
      o = v[32:0];
    end
    return o;
  endfunction

endpackage

[hdl/foc_voltage_sine_pwm_unit.sv]
// ----------------------------------------------------------------------------
// FOC voltage-mode sine PWM unit
// Inverse Park/Clarke commutation of a Uq command into three phase duties.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one transaction per update: a
//   signed Uq command in millivolts and a 16-bit electrical angle. Result
//   channel (out_valid/out_stall) returns one transaction per input with the
//   three phase duties, 255 meaning full supply, in input order.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_wdata) sets the supply
//   in millivolts (index 0) and the electrical zero offset (index 1); write it
//   only while no transaction is in flight. cfg_ready is always high.
// Timing:
//   13 register stages: a transaction accepted on the input channel passes
//   through each stage in order and is presented on the result channel.
//   One transaction per cycle is accepted unless in_stall; the depth is set
//   by the four chained multiplies of the sine polynomial, the Uq products
//   and the 8-bit quotient, two bits per stage over four divider stages.
// Reset and stall:
//   Reset empties the pipeline and loads supply 5000 mV and offset 0. A
//   stalled result holds; upstream stages keep advancing into empty slots,
//   and in_stall rises only once every stage holds a transaction.
// ----------------------------------------------------------------------------
`include "foc_voltage_sine_pwm_unit_assert.svh"

module foc_voltage_sine_pwm_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_uq_mv,
  input  logic        [15:0] in_elec_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic        [7:0]  out_duty_a,
  output logic        [7:0]  out_duty_b,
  output logic        [7:0]  out_duty_c,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [1:0]  cfg_index,
  input  logic        [15:0] cfg_wdata
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] supply_r;
  logic [15:0] offset_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      supply_r <= fvsp_pkg::SUPPLY_RST;
      offset_r <= fvsp_pkg::OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (fvsp_pkg::cfg_reg_t'(cfg_index))
        fvsp_pkg::CFG_SUPPLY_MV:   supply_r <= cfg_wdata;
        fvsp_pkg::CFG_ZERO_OFFSET: offset_r <= cfg_wdata;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or its successor loads,
  // so bubbles collapse while the result channel stalls.
  // --------------------------------------------------------------------------
  logic [fvsp_pkg::PIPE_DEPTH:1]   vld_r;
  logic [fvsp_pkg::PIPE_DEPTH:1]   vld_nxt;
  logic [fvsp_pkg::PIPE_DEPTH+1:1] adv;

  always_comb begin
    adv[fvsp_pkg::PIPE_DEPTH+1] = !out_stall;
    for (int k = fvsp_pkg::PIPE_DEPTH; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
    vld_nxt = vld_r;
    if (adv[1]) begin
      vld_nxt[1] = in_valid;
    end
    for (int k = 2; k <= fvsp_pkg::PIPE_DEPTH; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !adv[1];
  assign out_valid = vld_r[fvsp_pkg::PIPE_DEPTH];

  // --------------------------------------------------------------------------
  // Stage 1: Uq in half-millivolts clamped to +-supply/2 mV, angle plus offset
  // --------------------------------------------------------------------------
  logic signed [17:0] s1_uq2_r;
  logic signed [17:0] s1_uq2_nxt;
  logic        [15:0] s1_phase_r;

  always_comb begin
    logic signed [17:0] uq2;
    logic signed [17:0] sup;
    uq2 = 18'(in_uq_mv) <<< 1;
    sup = $signed({2'b00, supply_r});
    if (uq2 > sup) begin
      s1_uq2_nxt = sup;
    end else if (uq2 < -sup) begin
      s1_uq2_nxt = -sup;
    end else begin
      s1_uq2_nxt = uq2;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 2-5: sine (lane 0) and cosine (lane 1) by quarter-wave polynomial
  // --------------------------------------------------------------------------
  logic signed [17:0] s2_uq2_r;
  logic        [14:0] s2_x_r   [2];
  logic        [14:0] s2_x2_r  [2];
  logic               s2_neg_r [2];
  logic        [14:0] s2_x_nxt   [2];
  logic        [14:0] s2_x2_nxt  [2];
  logic               s2_neg_nxt [2];

  logic signed [17:0] s3_uq2_r;
  logic        [14:0] s3_x_r   [2];
  logic        [14:0] s3_x2_r  [2];
  logic               s3_neg_r [2];
  logic        [14:0] s3_t_r   [2];
  logic        [14:0] s3_t_nxt [2];

  logic signed [17:0] s4_uq2_r;
  logic        [14:0] s4_x_r   [2];
  logic               s4_neg_r [2];
  logic        [15:0] s4_t_r   [2];
  logic        [15:0] s4_t_nxt [2];

  logic signed [17:0] s5_uq2_r;
  logic signed [15:0] s5_sc_r   [2];
  logic signed [15:0] s5_sc_nxt [2];

  always_comb begin
    logic [15:0] ph;
    logic [29:0] pxx;
    logic [26:0] pc;
    logic [29:0] pb;
    logic [30:0] pa;
    logic [15:0] mag;
    logic [14:0] sat;
    for (int l = 0; l < 2; l++) begin
      // fold the phase into the first quadrant
      ph            = (l == 0) ? s1_phase_r : s1_phase_r + fvsp_pkg::QUARTER_PH;
      s2_neg_nxt[l] = ph[15];
      s2_x_nxt[l]   = ph[14] ? fvsp_pkg::QUARTER_X - {1'b0, ph[13:0]} : {1'b0, ph[13:0]};
      pxx           = 30'(s2_x_nxt[l]) * 30'(s2_x_nxt[l]);
      s2_x2_nxt[l]  = pxx[28:14];

      pc            = 27'(fvsp_pkg::SIN_C) * 27'(s2_x2_r[l]);
      s3_t_nxt[l]   = fvsp_pkg::SIN_B - {3'b000, pc[25:14]};

      pb            = 30'(s3_t_r[l]) * 30'(s3_x2_r[l]);
      s4_t_nxt[l]   = 16'(fvsp_pkg::SIN_A) - {1'b0, pb[28:14]};

      pa            = 31'(s4_t_r[l]) * 31'(s4_x_r[l]);
      mag           = pa[29:14];
      sat           = (mag > 16'(fvsp_pkg::SIN_SAT)) ? fvsp_pkg::SIN_SAT : mag[14:0];
      s5_sc_nxt[l]  = s4_neg_r[l] ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: inverse Park, alpha = -Uq*sin, beta = Uq*cos
  // Stage 7: beta*sqrt(3), floored by 16 bits
  // --------------------------------------------------------------------------
  logic signed [31:0] s6_al_r;
  logic signed [31:0] s6_be_r;
  logic signed [31:0] s6_al_nxt;
  logic signed [31:0] s6_be_nxt;
  logic signed [31:0] s7_al_r;
  logic signed [33:0] s7_k_r;
  logic signed [33:0] s7_k_nxt;

  always_comb begin
    logic signed [33:0] pal;
    logic signed [33:0] pbe;
    logic signed [50:0] pk;
    pal       = s5_uq2_r * s5_sc_r[0];
    pbe       = s5_uq2_r * s5_sc_r[1];
    s6_al_nxt = 32'(-pal);
    s6_be_nxt = 32'(pbe);
    pk        = s6_be_r * $signed(19'(fvsp_pkg::SQRT3_Q16));
    s7_k_nxt  = pk[49:16];
  end

  // --------------------------------------------------------------------------
  // Stage 8: inverse Clarke around supply/2, clamp to 0..supply
  // Stage 9: scale by 255 and drop the 2^17 part of the divisor
  // --------------------------------------------------------------------------
  logic [32:0] s8_v_r   [fvsp_pkg::NUM_PHASES];
  logic [32:0] s8_v_nxt [fvsp_pkg::NUM_PHASES];
  logic [23:0] s9_n_r   [fvsp_pkg::NUM_PHASES];
  logic [23:0] s9_n_nxt [fvsp_pkg::NUM_PHASES];

  always_comb begin
    logic signed [35:0] al;
    logic signed [35:0] k;
    logic signed [35:0] ctr;
    logic        [32:0] vmax;
    logic        [40:0] p255;
    al   = 36'(s7_al_r);
    k    = 36'(s7_k_r);
    ctr  = $signed({4'b0000, supply_r, 16'h0000});
    vmax = {supply_r, 17'h00000};
    s8_v_nxt[0] = fvsp_pkg::clamp_v((al <<< 1) + ctr, vmax);
    s8_v_nxt[1] = fvsp_pkg::clamp_v(k - al + ctr, vmax);
    s8_v_nxt[2] = fvsp_pkg::clamp_v(-al - k + ctr, vmax);
    for (int p = 0; p < fvsp_pkg::NUM_PHASES; p++) begin
      p255        = {s8_v_r[p], 8'h00} - {8'h00, s8_v_r[p]};
      s9_n_nxt[p] = p255[40:17];
    end
  end

  // --------------------------------------------------------------------------
  // Stages 10-13: restoring divide by supply, two quotient bits per stage
  // --------------------------------------------------------------------------
  fvsp_pkg::div_t div_r   [fvsp_pkg::DIV_STAGES][fvsp_pkg::NUM_PHASES];
  fvsp_pkg::div_t div_nxt [fvsp_pkg::DIV_STAGES][fvsp_pkg::NUM_PHASES];

  always_comb begin
    fvsp_pkg::div_t cur;
    for (int d = 0; d < fvsp_pkg::DIV_STAGES; d++) begin
      for (int p = 0; p < fvsp_pkg::NUM_PHASES; p++) begin
        if (d == 0) begin
          cur.rem = s9_n_r[p];
          cur.q   = '0;
        end else begin
          cur = div_r[(d == 0) ? 0 : d-1][p];
        end
        cur = fvsp_pkg::div_step(cur, supply_r, 3'(2 * (fvsp_pkg::DIV_STAGES - d) - 1));
        cur = fvsp_pkg::div_step(cur, supply_r, 3'(2 * (fvsp_pkg::DIV_STAGES - d) - 2));
        div_nxt[d][p] = cur;
      end
    end
  end

  assign out_duty_a = div_r[fvsp_pkg::DIV_STAGES-1][0].q;
  assign out_duty_b = div_r[fvsp_pkg::DIV_STAGES-1][1].q;
  assign out_duty_c = div_r[fvsp_pkg::DIV_STAGES-1][2].q;

  // --------------------------------------------------------------------------
  // Payload registers: advance with their stage, hold otherwise
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_uq2_r   <= s1_uq2_nxt;
      s1_phase_r <= in_elec_angle + offset_r;
    end
    if (adv[2]) begin
      s2_uq2_r <= s1_uq2_r;
      s2_x_r   <= s2_x_nxt;
      s2_x2_r  <= s2_x2_nxt;
      s2_neg_r <= s2_neg_nxt;
    end
    if (adv[3]) begin
      s3_uq2_r <= s2_uq2_r;
      s3_x_r   <= s2_x_r;
      s3_x2_r  <= s2_x2_r;
      s3_neg_r <= s2_neg_r;
      s3_t_r   <= s3_t_nxt;
    end
    if (adv[4]) begin
      s4_uq2_r <= s3_uq2_r;
      s4_x_r   <= s3_x_r;
      s4_neg_r <= s3_neg_r;
      s4_t_r   <= s4_t_nxt;
    end
    if (adv[5]) begin
      s5_uq2_r <= s4_uq2_r;
      s5_sc_r  <= s5_sc_nxt;
    end
    if (adv[6]) begin
      s6_al_r <= s6_al_nxt;
      s6_be_r <= s6_be_nxt;
    end
    if (adv[7]) begin
      s7_al_r <= s6_al_r;
      s7_k_r  <= s7_k_nxt;
    end
    if (adv[8]) begin
      s8_v_r <= s8_v_nxt;
    end
    if (adv[9]) begin
      s9_n_r <= s9_n_nxt;
    end
    for (int d = 0; d < fvsp_pkg::DIV_STAGES; d++) begin
      if (adv[10+d]) begin
        div_r[d] <= div_nxt[d];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic pre_out_vld;
  logic out_adv;

  assign pre_out_vld = vld_r[fvsp_pkg::PIPE_DEPTH-1];
  assign out_adv     = adv[fvsp_pkg::PIPE_DEPTH];

  `FVSP_ASSERT_SAME(a_full_blocks_in, (&vld_r) && out_stall, in_stall, "full pipe took input")
  `FVSP_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, vld_r[1], "accepted transaction lost")
  `FVSP_ASSERT_NEXT(a_handoff_out, pre_out_vld && out_adv, out_valid, "lost before output")
  `FVSP_ASSERT_NEXT(a_s8_hold, vld_r[8] && !adv[8], $stable({vld_r[8], s8_v_r[0]}), "hold broke")

endmodule
